/* src/idct8_pkg.sv */
// ----------------------------------------------------------------------------
// idct8_pkg
// shared register map, field widths and fixed-point constants of the 8-point idct
// ----------------------------------------------------------------------------
package idct8_pkg;

  // configuration register map
  localparam int unsigned NUM_REGS   = 7;
  localparam int unsigned REG_W      = 15;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_COEF_D   = 3'd3,
    REG_COEF_E   = 3'd4,
    REG_COEF_F   = 3'd5,
    REG_OUT_GAIN = 3'd6
  } reg_idx_e;

  // reset values, unsigned q1.14
  localparam logic [REG_W-1:0] RST_COEF_A   = 15'd22725;
  localparam logic [REG_W-1:0] RST_COEF_B   = 15'd21407;
  localparam logic [REG_W-1:0] RST_COEF_C   = 15'd19266;
  localparam logic [REG_W-1:0] RST_COEF_D   = 15'd12873;
  localparam logic [REG_W-1:0] RST_COEF_E   = 15'd8867;
  localparam logic [REG_W-1:0] RST_COEF_F   = 15'd4520;
  localparam logic [REG_W-1:0] RST_OUT_GAIN = 15'd5793;

  // fixed-point layout
  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned GAIN_SHIFT = 28;
  localparam int unsigned NUM_LANES  = 8;

endpackage : idct8_pkg

/* src/idct_8point_vector.sv */
// ----------------------------------------------------------------------------
// idct_8point_vector
// 1-d 8-point inverse dct on one coefficient vector per transaction
// five register stages; the first one loads at the edge that accepts the input
// throughput: one vector per cycle while the output is not stalled,
// every stage can load in every cycle
// a stalled output holds the pipeline; bubbles collapse while it waits
// reset: async active low, clears all stage valids and loads default weights
// ----------------------------------------------------------------------------
module idct_8point_vector
  import idct8_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: coef_in0, coef_in1, ... coef_in7 from the lowest bit up, zero padded
  input  logic [((8*COEF_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  // output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: sample_out0, sample_out1, ... sample_out7 from the lowest bit up, zero padded
  output logic [((8*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // widths of the datapath
  localparam int unsigned PR_W      = COEF_WIDTH + REG_W + 1;      // weight product
  localparam int unsigned ACC_W     = COEF_WIDTH + REG_W + 3;      // up to seven terms
  localparam int unsigned PW        = ACC_W + REG_W + 1;           // gain product
  localparam int unsigned RB_W      = PW + 1;                      // with rounding bias
  localparam int unsigned SH_W      = RB_W - GAIN_SHIFT;
  localparam int unsigned EXT_W     = (SH_W > SAMPLE_WIDTH ? SH_W : SAMPLE_WIDTH) + 1;

  localparam logic signed [RB_W-1:0]  ROUND_BIAS = RB_W'(1) << (GAIN_SHIFT - 1);
  localparam logic signed [EXT_W-1:0] SAT_MAX =
    {{(EXT_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SAT_MIN =
    {{(EXT_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [PR_W-1:0]       prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [PW-1:0]         gprod_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [REG_W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, coef_e_q, coef_f_q;
  logic [REG_W-1:0] out_gain_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;
  logic [REG_W-1:0] cfg_rd;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q   <= RST_COEF_A;
      coef_b_q   <= RST_COEF_B;
      coef_c_q   <= RST_COEF_C;
      coef_d_q   <= RST_COEF_D;
      coef_e_q   <= RST_COEF_E;
      coef_f_q   <= RST_COEF_F;
      out_gain_q <= RST_OUT_GAIN;
    end else if (cfg_wr) begin
      // only the low register bits are kept, unmapped index is dropped
      case (cfg_idx)
        REG_COEF_A:   coef_a_q   <= pwdata[REG_W-1:0];
        REG_COEF_B:   coef_b_q   <= pwdata[REG_W-1:0];
        REG_COEF_C:   coef_c_q   <= pwdata[REG_W-1:0];
        REG_COEF_D:   coef_d_q   <= pwdata[REG_W-1:0];
        REG_COEF_E:   coef_e_q   <= pwdata[REG_W-1:0];
        REG_COEF_F:   coef_f_q   <= pwdata[REG_W-1:0];
        REG_OUT_GAIN: out_gain_q <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COEF_A:   cfg_rd = coef_a_q;
      REG_COEF_B:   cfg_rd = coef_b_q;
      REG_COEF_C:   cfg_rd = coef_c_q;
      REG_COEF_D:   cfg_rd = coef_d_q;
      REG_COEF_E:   cfg_rd = coef_e_q;
      REG_COEF_F:   cfg_rd = coef_f_q;
      REG_OUT_GAIN: cfg_rd = out_gain_q;
      default:      cfg_rd = '0;
    endcase
  end

  assign prdata = APB_DATA_W'(cfg_rd);

  // --------------------------------------------------------------------------
  // pipeline flow control
  // a stage loads when it is empty or its content moves on this cycle
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || m_axis_tready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: weight products
  // odd inputs x1, x3, x5, x7 sit in lanes 0..3 of the odd product arrays
  // --------------------------------------------------------------------------
  coef_t x_in [NUM_LANES];
  prod_t pa_d [4], pc_d [4], pd_d [4], pf_d [4];
  prod_t pa_q [4], pc_q [4], pd_q [4], pf_q [4];
  prod_t pb2_d, pe2_d, pb6_d, pe6_d, pb2_q, pe2_q, pb6_q, pe6_q;
  acc_t  e0p_d, e0m_d, e0p_q, e0m_q;   // (x0 +- x4) scaled to 14 fraction bits

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      x_in[i] = s_axis_tdata_i[i*COEF_WIDTH +: COEF_WIDTH];
    end
    for (int j = 0; j < 4; j++) begin
      pa_d[j] = PR_W'(x_in[2*j+1]) * PR_W'($signed({1'b0, coef_a_q}));
      pc_d[j] = PR_W'(x_in[2*j+1]) * PR_W'($signed({1'b0, coef_c_q}));
      pd_d[j] = PR_W'(x_in[2*j+1]) * PR_W'($signed({1'b0, coef_d_q}));
      pf_d[j] = PR_W'(x_in[2*j+1]) * PR_W'($signed({1'b0, coef_f_q}));
    end
    pb2_d = PR_W'(x_in[2]) * PR_W'($signed({1'b0, coef_b_q}));
    pe2_d = PR_W'(x_in[2]) * PR_W'($signed({1'b0, coef_e_q}));
    pb6_d = PR_W'(x_in[6]) * PR_W'($signed({1'b0, coef_b_q}));
    pe6_d = PR_W'(x_in[6]) * PR_W'($signed({1'b0, coef_e_q}));
    e0p_d = (ACC_W'(x_in[0]) + ACC_W'(x_in[4])) <<< FRAC_BITS;
    e0m_d = (ACC_W'(x_in[0]) - ACC_W'(x_in[4])) <<< FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pa_q  <= pa_d;
      pc_q  <= pc_d;
      pd_q  <= pd_d;
      pf_q  <= pf_d;
      pb2_q <= pb2_d;
      pe2_q <= pe2_d;
      pb6_q <= pb6_d;
      pe6_q <= pe6_d;
      e0p_q <= e0p_d;
      e0m_q <= e0m_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: even and odd butterfly sums
  // --------------------------------------------------------------------------
  acc_t evp_d, evm_d, epp_d, epm_d, oa_d, ob_d, oc_d, od_d;
  acc_t evp_q, evm_q, epp_q, epm_q, oa_q, ob_q, oc_q, od_q;

  always_comb begin
    evp_d = e0p_q + ACC_W'(pb2_q) + ACC_W'(pe6_q);
    evm_d = e0p_q - ACC_W'(pb2_q) - ACC_W'(pe6_q);
    epp_d = e0m_q + ACC_W'(pe2_q) - ACC_W'(pb6_q);
    epm_d = e0m_q - ACC_W'(pe2_q) + ACC_W'(pb6_q);
    // lane 0 = x1, lane 1 = x3, lane 2 = x5, lane 3 = x7
    oa_d  = ACC_W'(pa_q[0]) + ACC_W'(pc_q[1]) + ACC_W'(pd_q[2]) + ACC_W'(pf_q[3]);
    ob_d  = ACC_W'(pa_q[3]) - ACC_W'(pf_q[0]) + ACC_W'(pd_q[1]) - ACC_W'(pc_q[2]);
    oc_d  = ACC_W'(pc_q[0]) - ACC_W'(pd_q[3]) - ACC_W'(pf_q[1]) - ACC_W'(pa_q[2]);
    od_d  = ACC_W'(pd_q[0]) + ACC_W'(pc_q[3]) - ACC_W'(pa_q[1]) + ACC_W'(pf_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      evp_q <= evp_d;
      evm_q <= evm_d;
      epp_q <= epp_d;
      epm_q <= epm_d;
      oa_q  <= oa_d;
      ob_q  <= ob_d;
      oc_q  <= oc_d;
      od_q  <= od_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: output butterfly, lanes in sample order
  // --------------------------------------------------------------------------
  acc_t y_d [NUM_LANES];
  acc_t y_q [NUM_LANES];

  always_comb begin
    y_d[0] = evp_q + oa_q;
    y_d[7] = evp_q - oa_q;
    y_d[4] = evm_q + ob_q;
    y_d[3] = evm_q - ob_q;
    y_d[1] = epp_q + oc_q;
    y_d[6] = epp_q - oc_q;
    y_d[2] = epm_q + od_q;
    y_d[5] = epm_q - od_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3) y_q <= y_d;
  end

  // --------------------------------------------------------------------------
  // stage 4: gain product, 28 fraction bits
  // --------------------------------------------------------------------------
  gprod_t g_d [NUM_LANES];
  gprod_t g_q [NUM_LANES];

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      g_d[i] = PW'(y_q[i]) * PW'($signed({1'b0, out_gain_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) g_q <= g_d;
  end

  // --------------------------------------------------------------------------
  // stage 5: round half up, drop fraction, saturate, output register
  // --------------------------------------------------------------------------
  logic signed [RB_W-1:0]         biased  [NUM_LANES];
  logic signed [SH_W-1:0]         shifted [NUM_LANES];
  logic signed [EXT_W-1:0]        ext     [NUM_LANES];
  logic        [SAMPLE_WIDTH-1:0] sat_d   [NUM_LANES];
  logic        [SAMPLE_WIDTH-1:0] sat_q   [NUM_LANES];

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      biased[i]  = RB_W'(g_q[i]) + ROUND_BIAS;
      shifted[i] = biased[i][RB_W-1:GAIN_SHIFT];
      ext[i]     = EXT_W'(shifted[i]);
      if (ext[i] > SAT_MAX) begin
        sat_d[i] = SAT_MAX[SAMPLE_WIDTH-1:0];
      end else if (ext[i] < SAT_MIN) begin
        sat_d[i] = SAT_MIN[SAMPLE_WIDTH-1:0];
      end else begin
        sat_d[i] = ext[i][SAMPLE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) sat_q <= sat_d;
  end

  always_comb begin
    m_axis_tdata_o = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      m_axis_tdata_o[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = sat_q[i];
    end
  end

endmodule : idct_8point_vector

/* src/idct8_checker.sv */
// ----------------------------------------------------------------------------
// idct8_checker
// port-level checks of the 8-point idct, bound to the top level
// ----------------------------------------------------------------------------
module idct8_checker
  import idct8_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  // tdata: sample_out0 ... sample_out7 from the lowest bit up
  input logic [((8*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready
);

  logic cfg_wr;
  logic cfg_in_map;

  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_in_map = (paddr[APB_ADDR_W-1:2] != 3'(NUM_REGS));

  // the pipeline is empty while reset is applied
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // a held result keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output changed");

  // input backpressure only comes from a stalled full pipeline
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output stall");

  // a written register reads back its low bits
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && cfg_in_map |=>
      (paddr != $past(paddr)) || (prdata == APB_DATA_W'($past(pwdata[REG_W-1:0]))))
    else $error("register readback mismatch");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule : idct8_checker

bind idct_8point_vector idct8_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_idct8_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata),
  .pready         (pready)
);
